@@ sv/source_line_classifier_unit_defines.svh @@
// assertion macros for the source line classifier
`ifndef SOURCE_LINE_CLASSIFIER_UNIT_DEFINES_SVH
`define SOURCE_LINE_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SLC_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("source line classifier check failed");
`define SLC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("source line classifier check failed");
`else
`define SLC_ASSERT_SAME(label, clk, rst, cond, prop)
`define SLC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

@@ sv/slc_pkg.sv @@
// shared types, character codes and the per-byte flag update
package slc_pkg;

   localparam int TEXT_W      = 8;
   localparam int COUNT_FLD_W = 24;
   localparam int CODE_FLD_W  = 27;
   localparam int RSP_DATA_W  = 232;

   localparam logic [TEXT_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [TEXT_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [TEXT_W-1:0] CHAR_CR      = 8'h0D;
   localparam logic [TEXT_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [TEXT_W-1:0] CHAR_STAR    = 8'h2A;
   localparam logic [TEXT_W-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [TEXT_W-1:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [TEXT_W-1:0] CHAR_RBRACE  = 8'h7D;

   typedef struct packed {
      logic dslash;
      logic slash;
      logic pretext;
      logic notblank;
      logic ns_one;
      logic ns_many;
      logic ns_brace;
      logic open_pair;
      logic close_pair;
   } line_flags_type;

   function automatic line_flags_type take_byte(input line_flags_type flags,
                                                input logic [TEXT_W-1:0] prev,
                                                input logic [TEXT_W-1:0] c);
      line_flags_type f;
      logic is_slash;
      logic is_ws;
      logic is_sp_tab;
      f         = flags;
      is_slash  = (c == CHAR_SLASH);
      is_ws     = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      is_sp_tab = (c == CHAR_SPACE) || (c == CHAR_TAB);
      if (is_slash) begin
         if (prev == CHAR_SLASH) f.dslash = 1'b1;
         if (prev == CHAR_STAR) f.close_pair = 1'b1;
         f.slash = 1'b1;
      end else if (!flags.slash && (c != CHAR_SPACE)) begin
         f.pretext = 1'b1;
      end
      if ((c == CHAR_STAR) && (prev == CHAR_SLASH)) f.open_pair = 1'b1;
      if (!is_ws) f.notblank = 1'b1;
      if (!is_sp_tab) begin
         if (flags.ns_one) begin
            f.ns_many = 1'b1;
         end else begin
            f.ns_one = 1'b1;
            if ((c == CHAR_LBRACE) || (c == CHAR_RBRACE)) f.ns_brace = 1'b1;
         end
      end
      return f;
   endfunction

endpackage

@@ sv/source_line_classifier_unit.sv @@
// path: the final byte of a text goes from the input register through the counters into
//   the snapshot register, then into the output register, which raises rsp_tvalid
// throughput: one byte per cycle; the input stalls only when a final byte waits while
//   both snapshot and output registers are full and rsp_tready is low
// reset: synchronous, active high; clears all counters, line state and valid flags
// top level of the source line classifier
`include "source_line_classifier_unit_defines.svh"

module source_line_classifier_unit #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [slc_pkg::TEXT_W-1:0]     req_tdata,   // text_byte
   input  logic                           req_tlast,   // end_of_text
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // total_lines, line_comment_lines, blank_lines, brace_lines, block_comment_lines,
   // code_lines, code_lines_no_blank, code_lines_no_brace, code_lines_no_both, zero pad
   output logic [slc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import slc_pkg::*;

   localparam int XW = (COUNT_WIDTH > CODE_FLD_W) ? COUNT_WIDTH : CODE_FLD_W;

   // input register
   logic              in_valid_ff;
   logic [TEXT_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // snapshot of the final counts
   logic                   snap_valid_ff;
   logic [COUNT_WIDTH-1:0] snap_total_ff, snap_comment_ff, snap_blank_ff;
   logic [COUNT_WIDTH-1:0] snap_brace_ff, snap_block_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [COUNT_FLD_W-1:0] out_total_ff, out_comment_ff, out_blank_ff;
   logic [COUNT_FLD_W-1:0] out_brace_ff, out_block_ff;
   logic [CODE_FLD_W-1:0]  out_code_ff, out_code_nb_ff, out_code_nbr_ff, out_code_both_ff;

   logic [COUNT_WIDTH-1:0] fin_total, fin_comment, fin_blank, fin_brace, fin_block;
   logic                   out_move, snap_free, proc_go;
   logic [CODE_FLD_W-1:0]  c_total, c_comment, c_blank, c_brace, c_block, c_code;
   logic                   derived_ok;

   assign out_move   = snap_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign snap_free  = !snap_valid_ff || out_move;
   assign proc_go    = in_valid_ff && (!in_last_ff || snap_free);
   assign req_tready = !in_valid_ff || proc_go;

   slc_tally #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_tally (
      .clock           (clock),
      .reset           (reset),
      .step            (proc_go),
      .text_byte       (in_byte_ff),
      .end_of_text     (in_last_ff),
      .fin_total       (fin_total),
      .fin_line_comment(fin_comment),
      .fin_blank       (fin_blank),
      .fin_brace       (fin_brace),
      .fin_block       (fin_block)
   );

   // derived figures only need the low bits of each difference
   assign c_total   = CODE_FLD_W'(XW'(snap_total_ff));
   assign c_comment = CODE_FLD_W'(XW'(snap_comment_ff));
   assign c_blank   = CODE_FLD_W'(XW'(snap_blank_ff));
   assign c_brace   = CODE_FLD_W'(XW'(snap_brace_ff));
   assign c_block   = CODE_FLD_W'(XW'(snap_block_ff));
   assign c_code    = c_total - c_comment - c_block;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (proc_go && in_last_ff) begin
            snap_valid_ff <= 1'b1;
         end else if (out_move) begin
            snap_valid_ff <= 1'b0;
         end
         if (out_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (proc_go && in_last_ff) begin
         snap_total_ff   <= fin_total;
         snap_comment_ff <= fin_comment;
         snap_blank_ff   <= fin_blank;
         snap_brace_ff   <= fin_brace;
         snap_block_ff   <= fin_block;
      end
      if (out_move) begin
         out_total_ff     <= COUNT_FLD_W'(XW'(snap_total_ff));
         out_comment_ff   <= COUNT_FLD_W'(XW'(snap_comment_ff));
         out_blank_ff     <= COUNT_FLD_W'(XW'(snap_blank_ff));
         out_brace_ff     <= COUNT_FLD_W'(XW'(snap_brace_ff));
         out_block_ff     <= COUNT_FLD_W'(XW'(snap_block_ff));
         out_code_ff      <= c_code;
         out_code_nb_ff   <= c_total - c_comment - c_block - c_blank;
         out_code_nbr_ff  <= c_total - c_comment - c_block - c_brace;
         out_code_both_ff <= c_total - c_comment - c_block - c_brace - c_blank;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_code_both_ff, out_code_nbr_ff, out_code_nb_ff,
                        out_code_ff, out_block_ff, out_brace_ff, out_blank_ff,
                        out_comment_ff, out_total_ff};

   // both pairs of derived figures differ by the brace count
   assign derived_ok = (out_code_ff - out_code_nbr_ff) == (out_code_nb_ff - out_code_both_ff);

   `SLC_ASSERT_NEXT(a_final_snap, clock, reset, proc_go && in_last_ff, snap_valid_ff)
   `SLC_ASSERT_NEXT(a_move_out, clock, reset, out_move, rsp_valid_ff)
   `SLC_ASSERT_SAME(a_derived_link, clock, reset, rsp_valid_ff, derived_ok)

endmodule

@@ sv/slc_tally.sv @@
// per-line classification state and saturating line counters
module slc_tally #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [slc_pkg::TEXT_W-1:0] text_byte,
   input  logic                       end_of_text,
   output logic [COUNT_WIDTH-1:0]     fin_total,
   output logic [COUNT_WIDTH-1:0]     fin_line_comment,
   output logic [COUNT_WIDTH-1:0]     fin_blank,
   output logic [COUNT_WIDTH-1:0]     fin_brace,
   output logic [COUNT_WIDTH-1:0]     fin_block
);
   import slc_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   logic [COUNT_WIDTH-1:0] line_ff, line_in;
   logic [COUNT_WIDTH-1:0] comment_ff, comment_in;
   logic [COUNT_WIDTH-1:0] blank_ff, blank_in;
   logic [COUNT_WIDTH-1:0] brace_ff, brace_in;
   logic [COUNT_WIDTH-1:0] block_ff, block_in;
   logic [COUNT_WIDTH-1:0] span_ff, span_in;
   logic                   inside_ff, inside_in;
   logic [TEXT_W-1:0]      prev_ff, prev_in;
   line_flags_type         flags_ff, flags_in;

   line_flags_type         flags_take;
   line_flags_type         fl;
   logic                   line_end;
   logic                   open_now;
   logic                   inside_mid;
   logic                   close_now;
   logic [COUNT_WIDTH-1:0] span_cur;
   logic [COUNT_WIDTH:0]   block_sum;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
      return (x == CNT_MAX) ? x : x + CNT_ONE;
   endfunction

   always_comb begin
      flags_take = take_byte(flags_ff, prev_ff, text_byte);
      line_end   = (text_byte == CHAR_NEWLINE) || end_of_text;
      fl         = (text_byte == CHAR_NEWLINE) ? flags_ff : flags_take;

      open_now   = fl.open_pair && !inside_ff;
      inside_mid = inside_ff || fl.open_pair;
      close_now  = fl.close_pair && inside_mid;
      // span grows with the line number, so it stops once the line count saturates
      span_cur   = open_now ? CNT_ONE :
                   ((line_ff == CNT_MAX) ? span_ff : span_ff + CNT_ONE);
      block_sum  = {1'b0, block_ff} + {1'b0, span_cur};

      line_in    = line_ff;
      comment_in = comment_ff;
      blank_in   = blank_ff;
      brace_in   = brace_ff;
      block_in   = block_ff;
      span_in    = span_ff;
      inside_in  = inside_ff;
      flags_in   = flags_take;
      prev_in    = text_byte;
      if (line_end) begin
         line_in = sat_inc(line_ff);
         if (fl.dslash && !fl.pretext) comment_in = sat_inc(comment_ff);
         if (!fl.notblank) blank_in = sat_inc(blank_ff);
         if (fl.ns_one && fl.ns_brace && !fl.ns_many) brace_in = sat_inc(brace_ff);
         if (close_now) begin
            block_in = block_sum[COUNT_WIDTH] ? CNT_MAX : block_sum[COUNT_WIDTH-1:0];
         end
         if (inside_mid) span_in = span_cur;
         inside_in = inside_mid && !close_now;
         flags_in  = '0;
         prev_in   = '0;
      end
   end

   assign fin_total        = line_in;
   assign fin_line_comment = comment_in;
   assign fin_blank        = blank_in;
   assign fin_brace        = brace_in;
   assign fin_block        = block_in;

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_text)) begin
         line_ff    <= '0;
         comment_ff <= '0;
         blank_ff   <= '0;
         brace_ff   <= '0;
         block_ff   <= '0;
         span_ff    <= '0;
         inside_ff  <= 1'b0;
         prev_ff    <= '0;
         flags_ff   <= '0;
      end else if (step) begin
         line_ff    <= line_in;
         comment_ff <= comment_in;
         blank_ff   <= blank_in;
         brace_ff   <= brace_in;
         block_ff   <= block_in;
         span_ff    <= span_in;
         inside_ff  <= inside_in;
         prev_ff    <= prev_in;
         flags_ff   <= flags_in;
      end
   end

endmodule

@@ bench/source_line_classifier_unit_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the source line classifier: directed and random texts against a line census model
module source_line_classifier_unit_tb;
   import slc_pkg::*;

   localparam int CENSUS_W     = 5 * COUNT_FLD_W + 4 * CODE_FLD_W;
   localparam int STUCK_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [COUNT_FLD_W-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_FLD_W-1:0] COUNT_ONE = COUNT_FLD_W'(1);
   localparam logic [TEXT_W-1:0] CHAR_VTAB = 8'h0B;
   localparam logic [TEXT_W-1:0] CHAR_FF   = 8'h0C;

   // first member sits in the top bits, so total_lines lands at bit 0
   typedef struct packed {
      logic [CODE_FLD_W-1:0]  no_both;
      logic [CODE_FLD_W-1:0]  no_brace;
      logic [CODE_FLD_W-1:0]  no_blank;
      logic [CODE_FLD_W-1:0]  code;
      logic [COUNT_FLD_W-1:0] block;
      logic [COUNT_FLD_W-1:0] brace;
      logic [COUNT_FLD_W-1:0] blank;
      logic [COUNT_FLD_W-1:0] comment;
      logic [COUNT_FLD_W-1:0] total;
   } census_type;

   typedef enum {
      LK_BLANK, LK_LINE_COMMENT, LK_TRAILING_COMMENT, LK_BRACE,
      LK_SPAN_OPEN, LK_SPAN_CLOSE, LK_OVERLAP, LK_CODE, LK_NOISE
   } line_kind_type;

   class line_census_board_type;
      census_type expected_q[$];
      int unsigned failures;
      logic [COUNT_FLD_W-1:0] lines, comments, blanks, braces, blocks, span_start;
      logic in_span;
      logic [TEXT_W-1:0] prev;
      logic dslash, slash, pretext, notblank, ns_one, ns_many, ns_brace, open_pair, close_pair;

      function new();
         failures = 0;
         clear_text();
      endfunction

      function void clear_line();
         {dslash, slash, pretext, notblank, ns_one, ns_many, ns_brace, open_pair, close_pair} = '0;
         prev = '0;
      endfunction

      function void clear_text();
         {lines, comments, blanks, braces, blocks, span_start} = '0;
         in_span = 1'b0;
         clear_line();
      endfunction

      function logic [COUNT_FLD_W-1:0] sat_sum(logic [COUNT_FLD_W-1:0] a,
                                               logic [COUNT_FLD_W-1:0] b);
         logic [COUNT_FLD_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[COUNT_FLD_W] ? COUNT_MAX : s[COUNT_FLD_W-1:0];
      endfunction

      function void absorb(logic [TEXT_W-1:0] c);
         if (c == CHAR_SLASH) begin
            if (prev == CHAR_SLASH) dslash = 1'b1;
            if (prev == CHAR_STAR) close_pair = 1'b1;
            slash = 1'b1;
         end else if (!slash && c != CHAR_SPACE) begin
            pretext = 1'b1;
         end
         if (c == CHAR_STAR && prev == CHAR_SLASH) open_pair = 1'b1;
         if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) notblank = 1'b1;
         if (c != CHAR_SPACE && c != CHAR_TAB) begin
            if (ns_one) begin
               ns_many = 1'b1;
            end else begin
               ns_one = 1'b1;
               if (c == CHAR_LBRACE || c == CHAR_RBRACE) ns_brace = 1'b1;
            end
         end
         prev = c;
      endfunction

      function void close_line();
         logic [COUNT_FLD_W-1:0] here;
         here = sat_sum(lines, COUNT_ONE);
         lines = here;
         if (dslash && !pretext) comments = sat_sum(comments, COUNT_ONE);
         if (!notblank) blanks = sat_sum(blanks, COUNT_ONE);
         if (ns_one && ns_brace && !ns_many) braces = sat_sum(braces, COUNT_ONE);
         if (open_pair && !in_span) begin
            in_span = 1'b1;
            span_start = here;
         end
         if (close_pair && in_span) begin
            in_span = 1'b0;
            blocks = sat_sum(blocks, sat_sum(here - span_start, COUNT_ONE));
         end
         clear_line();
      endfunction

      function void note_text_byte(logic [TEXT_W-1:0] c, logic last);
         census_type e;
         longint code, diff;
         if (c == CHAR_NEWLINE) begin
            close_line();
         end else begin
            absorb(c);
            if (last) close_line();
         end
         if (last) begin
            e.total   = lines;
            e.comment = comments;
            e.blank   = blanks;
            e.brace   = braces;
            e.block   = blocks;
            code = longint'(lines) - longint'(comments) - longint'(blocks);
            e.code = code[CODE_FLD_W-1:0];
            diff = code - longint'(blanks);
            e.no_blank = diff[CODE_FLD_W-1:0];
            diff = code - longint'(braces);
            e.no_brace = diff[CODE_FLD_W-1:0];
            diff = code - longint'(braces) - longint'(blanks);
            e.no_both = diff[CODE_FLD_W-1:0];
            expected_q = {expected_q, e};
            clear_text();
         end
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_census(logic [RSP_DATA_W-1:0] data);
         census_type got, e;
         got = data[CENSUS_W-1:0];
         if (expected_q.size() == 0) begin
            $error("result transaction with no text pending");
            failures++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("total_lines", 64'(e.total), 64'(got.total));
         compare_field("line_comment_lines", 64'(e.comment), 64'(got.comment));
         compare_field("blank_lines", 64'(e.blank), 64'(got.blank));
         compare_field("brace_lines", 64'(e.brace), 64'(got.brace));
         compare_field("block_comment_lines", 64'(e.block), 64'(got.block));
         compare_field("code_lines", 64'($signed(e.code)), 64'($signed(got.code)));
         compare_field("code_lines_no_blank", 64'($signed(e.no_blank)),
                       64'($signed(got.no_blank)));
         compare_field("code_lines_no_brace", 64'($signed(e.no_brace)),
                       64'($signed(got.no_brace)));
         compare_field("code_lines_no_both", 64'($signed(e.no_both)),
                       64'($signed(got.no_both)));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [TEXT_W-1:0]     req_tdata;   // text_byte
   logic                  req_tlast;   // end_of_text
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // total_lines, line_comment_lines, blank_lines, brace_lines, block_comment_lines,
   // code_lines, code_lines_no_blank, code_lines_no_brace, code_lines_no_both, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;

   line_census_board_type census = new();
   bit gaps_on;
   bit hold_request;
   int unsigned bytes_sent;
   int unsigned stuck_cycles;
   logic [TEXT_W-1:0] text_q[$];
   string code_chars = "ab1;=(){}/* \t";

   source_line_classifier_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) census.note_text_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) census.check_census(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 37);
         end
      end
   end

   task automatic send_byte(input logic [TEXT_W-1:0] b, input logic last);
      while (gaps_on && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic void add_byte(logic [TEXT_W-1:0] b);
      text_q = {text_q, b};
   endfunction

   function automatic void push_string(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void push_code(int n);
      repeat (n) add_byte(code_chars[$urandom_range(0, code_chars.len() - 1)]);
   endfunction

   function automatic void push_pads(int n);
      repeat (n) add_byte($urandom_range(0, 1) ? CHAR_TAB : CHAR_SPACE);
   endfunction

   function automatic logic [TEXT_W-1:0] any_ws();
      case ($urandom_range(0, 4))
         0: return CHAR_TAB;
         1: return CHAR_VTAB;
         2: return CHAR_FF;
         3: return CHAR_CR;
         default: return CHAR_SPACE;
      endcase
   endfunction

   // mostly well-formed lines of every kind, with some raw byte noise mixed in
   function automatic void build_random_text();
      int n_lines;
      line_kind_type kind;
      text_q.delete();
      n_lines = $urandom_range(1, 14);
      for (int i = 0; i < n_lines; i++) begin
         kind = line_kind_type'($urandom_range(0, LK_NOISE));
         case (kind)
            LK_BLANK: begin
               repeat ($urandom_range(0, 4)) add_byte(any_ws());
            end
            LK_LINE_COMMENT: begin
               // a tab ahead of the slashes disqualifies the line
               repeat ($urandom_range(0, 3))
                  add_byte($urandom_range(0, 5) == 0 ? CHAR_TAB : CHAR_SPACE);
               push_string("//");
               push_code($urandom_range(0, 5));
            end
            LK_TRAILING_COMMENT: begin
               push_code($urandom_range(1, 4));
               push_string("//");
               push_code($urandom_range(0, 3));
            end
            LK_BRACE: begin
               push_pads($urandom_range(0, 3));
               add_byte($urandom_range(0, 1) ? CHAR_LBRACE : CHAR_RBRACE);
               if ($urandom_range(0, 3) == 0) add_byte(CHAR_RBRACE);
               push_pads($urandom_range(0, 3));
            end
            LK_SPAN_OPEN: begin
               push_code($urandom_range(0, 3));
               push_string("/*");
               push_code($urandom_range(0, 3));
            end
            LK_SPAN_CLOSE: begin
               push_code($urandom_range(0, 3));
               push_string("*/");
               push_code($urandom_range(0, 3));
            end
            LK_OVERLAP: begin
               if ($urandom_range(0, 1)) push_string("/*/");
               else push_string(" //*/");
            end
            LK_CODE: begin
               push_code($urandom_range(1, 8));
            end
            default: begin
               repeat ($urandom_range(1, 6)) add_byte(TEXT_W'($urandom_range(0, 255)));
            end
         endcase
         if (i < n_lines - 1 || $urandom_range(0, 1)) add_byte(CHAR_NEWLINE);
      end
      if (text_q.size() == 0) add_byte(CHAR_NEWLINE);
   endfunction

   task automatic send_random_texts(input int unsigned byte_goal);
      while (bytes_sent < byte_goal) begin
         build_random_text();
         for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      end
   endtask

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tlast    <= 1'b0;
      gaps_on      = 1'b1;
      hold_request = 1'b0;
      bytes_sent   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // lone newline as final byte: one empty line and nothing after it
      send_string("\n");
      // comment, tab-led comment, brace line, a three-line span, final byte kept in line
      send_string(" //x\n\t//\n {\t\n/*\n\015\013\n*/\377");
      // span left open at the end of text
      send_string("/*");

      send_random_texts(500);
      gaps_on = 1'b0;
      send_random_texts(800);

      // receiver holds off while single-byte texts pile up behind it
      hold_request = 1'b1;
      repeat (40) send_byte(TEXT_W'($urandom_range(0, 255)), 1'b1);
      gaps_on = 1'b1;
      send_random_texts(1400);
      req_tvalid <= 1'b0;

      while (census.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (census.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ source_line_classifier_unit.f @@
+incdir+sv
sv/slc_pkg.sv
sv/slc_tally.sv
sv/source_line_classifier_unit.sv
bench/source_line_classifier_unit_tb.sv
